[sv/ordered_list_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define OLE_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define OLE_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/olist_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list package
// Types, codes and sizes shared by the ordered list engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olist_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 8;

  // Operation codes.
  localparam logic [3:0] M_CREATE  = 4'd0;
  localparam logic [3:0] M_DESTROY = 4'd1;
  localparam logic [3:0] M_CLEAR   = 4'd2;
  localparam logic [3:0] M_GET     = 4'd3;
  localparam logic [3:0] M_LOCATE  = 4'd4;
  localparam logic [3:0] M_PRIOR   = 4'd5;
  localparam logic [3:0] M_NEXT    = 4'd6;
  localparam logic [3:0] M_INSERT  = 4'd7;
  localparam logic [3:0] M_DELETE  = 4'd8;

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_NOLIST = 3'd2;
  localparam logic [2:0] ST_EXISTS = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_TEST, S_PUT, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    C_NONE, C_LOAD, C_READ, C_TEST, C_PUT, C_EMIT
  } dp_op_t;

  typedef struct packed {
    logic   idle;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic need_mem;
    logic put_now;
    logic last;
    logic put_after;
    logic out_free;
  } sts_t;

endpackage

[sv/olist_in_if.sv]
// ----------------------------------------------------------------------------
// Operation channel
// Carries one list operation per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olist_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink (input valid, mode, position, value, output ready);
endinterface

[sv/olist_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olist_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] out_value;
  logic [7:0]         out_position;
  logic [7:0]         list_length;
  logic               list_empty;

  modport source (output valid, status, out_value, out_position, list_length, list_empty,
                  input ready);
  modport sink (input valid, status, out_value, out_position, list_length, list_empty,
                output ready);
endinterface

[sv/olist_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/olist_ctrl.sv]
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences load, memory steps, insert write and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  olist_pkg::sts_t sts,
  output olist_pkg::cmd_t cmd
);
  import olist_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd.idle   = 1'b0;
    cmd.op     = C_NONE;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.op = C_LOAD;
          if (sts.need_mem) begin
            state_next = S_READ;
          end else if (sts.put_now) begin
            state_next = S_PUT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_READ: begin
        cmd.op     = C_READ;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.op = C_TEST;
        if (!sts.last) begin
          state_next = S_READ;
        end else if (sts.put_after) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PUT: begin
        cmd.op     = C_PUT;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op     = C_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/olist_dp.sv]
// ----------------------------------------------------------------------------
// Ordered list datapath
// List state, element memory, scan and shift logic, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olist_dp (
  input  logic            clk,
  input  logic            rst,
  olist_in_if.sink        in_ch,
  olist_out_if.source     out_ch,
  input  olist_pkg::cmd_t cmd,
  output olist_pkg::sts_t sts
);
  import olist_pkg::*;

  logic [3:0]        op_r;
  logic [7:0]        pos_r;
  logic [31:0]       key_r;
  logic [ADDR_W-1:0] idx;
  logic [LEN_W-1:0]  len;
  logic              exists;
  logic [2:0]        status;
  logic [31:0]       oval;
  logic [7:0]        opos;
  logic [31:0]       prev;
  logic              first;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [31:0]       ram_wr_data;
  logic [31:0]       rd_data;

  logic [8:0]        len_plus;
  logic [7:0]        idx_inc;
  logic [7:0]        pos_dec;
  logic              pos_ok_rd;
  logic              pos_ok_ins;
  logic              room;
  logic              live;
  logic              hit;
  logic [7:0]        in_dec;

  olist_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.op == C_READ),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Checks on the incoming operation.
  assign len_plus   = {1'b0, len} + 9'd1;
  assign in_dec     = in_ch.position - 8'd1;
  assign pos_ok_rd  = (in_ch.position != 8'd0) && (in_ch.position <= len);
  assign pos_ok_ins = (in_ch.position != 8'd0) && ({1'b0, in_ch.position} <= len_plus);
  assign room       = len < LEN_W'(CAPACITY);
  assign live       = exists && (in_ch.mode != M_CREATE) && (in_ch.mode <= M_DELETE);

  // Scan helpers.
  assign idx_inc = {1'b0, idx} + 8'd1;
  assign pos_dec = pos_r - 8'd1;
  assign hit     = rd_data == key_r;

  // Status toward the controller.
  always_comb begin
    sts.in_valid  = in_ch.valid;
    sts.need_mem  = 1'b0;
    sts.put_now   = 1'b0;
    sts.out_free  = !out_ch.valid || out_ch.ready;
    sts.put_after = op_r == M_INSERT;
    sts.last      = 1'b1;
    if (live) begin
      case (in_ch.mode)
        M_GET, M_DELETE:
          sts.need_mem = pos_ok_rd;
        M_LOCATE, M_PRIOR, M_NEXT:
          sts.need_mem = len != '0;
        M_INSERT: begin
          sts.need_mem = pos_ok_ins && room && (in_ch.position <= len);
          sts.put_now  = pos_ok_ins && room && (in_ch.position > len);
        end
        default: ;
      endcase
    end
    case (op_r)
      M_LOCATE, M_PRIOR: sts.last = hit || (idx_inc == len);
      M_NEXT:            sts.last = hit || (idx == '0);
      M_INSERT:          sts.last = idx_inc == pos_r;
      M_DELETE:          sts.last = idx_inc >= len;
      default:           sts.last = 1'b1;
    endcase
  end

  // Memory write port: shifting moves and the final insert write.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = rd_data;
    if (cmd.op == C_TEST && op_r == M_INSERT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = idx + ADDR_W'(1);
    end else if (cmd.op == C_TEST && op_r == M_DELETE && !first) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = idx - ADDR_W'(1);
    end else if (cmd.op == C_PUT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pos_dec[ADDR_W-1:0];
      ram_wr_data = key_r;
    end
  end

  // List state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      exists <= 1'b0;
      len    <= '0;
    end else begin
      case (cmd.op)
        C_LOAD: begin
          op_r   <= in_ch.mode;
          pos_r  <= in_ch.position;
          key_r  <= in_ch.value;
          oval   <= '0;
          opos   <= '0;
          first  <= 1'b1;
          status <= ST_OK;
          idx    <= in_dec[ADDR_W-1:0];
          if (in_ch.mode > M_DELETE) begin
            status <= ST_MISS;
          end else if (in_ch.mode == M_CREATE) begin
            if (exists) begin
              status <= ST_EXISTS;
            end else begin
              exists <= 1'b1;
              len    <= '0;
            end
          end else if (!exists) begin
            status <= ST_NOLIST;
          end else begin
            case (in_ch.mode)
              M_DESTROY: begin
                exists <= 1'b0;
                len    <= '0;
              end
              M_CLEAR: len <= '0;
              M_GET, M_DELETE: begin
                if (!pos_ok_rd) begin
                  status <= ST_MISS;
                end
              end
              M_LOCATE, M_PRIOR: begin
                status <= ST_MISS;
                idx    <= '0;
              end
              M_NEXT: begin
                status <= ST_MISS;
                idx    <= ADDR_W'(len - 8'd1);
              end
              M_INSERT: begin
                idx <= ADDR_W'(len - 8'd1);
                if (!pos_ok_ins) begin
                  status <= ST_MISS;
                end else if (!room) begin
                  status <= ST_FULL;
                end
              end
              default: ;
            endcase
          end
        end
        C_TEST: begin
          case (op_r)
            M_GET: oval <= rd_data;
            M_LOCATE: begin
              if (hit) begin
                status <= ST_OK;
                opos   <= idx_inc;
              end else begin
                idx <= idx + ADDR_W'(1);
              end
            end
            M_PRIOR: begin
              prev <= rd_data;
              if (hit) begin
                if (idx != '0) begin
                  status <= ST_OK;
                  oval   <= prev;
                end
              end else begin
                idx <= idx + ADDR_W'(1);
              end
            end
            M_NEXT: begin
              prev <= rd_data;
              if (hit) begin
                if (idx_inc != len) begin
                  status <= ST_OK;
                  oval   <= prev;
                end
              end else begin
                idx <= idx - ADDR_W'(1);
              end
            end
            M_INSERT: idx <= idx - ADDR_W'(1);
            M_DELETE: begin
              first <= 1'b0;
              if (first) begin
                oval <= rd_data;
              end
              if (sts.last) begin
                len <= len - 8'd1;
              end else begin
                idx <= idx + ADDR_W'(1);
              end
            end
            default: ;
          endcase
        end
        C_PUT: len <= len + 8'd1;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.op == C_EMIT) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == C_EMIT) begin
      out_ch.status       <= status;
      out_ch.out_value    <= oval;
      out_ch.out_position <= opos;
      out_ch.list_length  <= len;
      out_ch.list_empty   <= exists && (len == '0);
    end
  end

  assign in_ch.ready = cmd.idle;

endmodule

[sv/ordered_list_engine_top.sv]
// Ordered list engine: a list of up to 128 signed 32-bit elements addressed
// by 1-based positions. Each transfer on in_ch is one operation (create,
// destroy, clear, get, locate, prior, next, insert, delete) and yields
// exactly one transfer on out_ch with status, value, position, length and
// emptiness after the operation.
// Operations are handled one at a time. The element memory has a single read
// port with registered data, so every memory step is a read followed by a
// test or move. Create, destroy, clear and rejected items go from the load
// straight to the result register; get does one memory step; locate, prior
// and next do one step per entry visited; insert and delete do one step per
// entry from the position to the end, and insert then writes the new element.
// in_ch.ready is high only while the engine is idle. A finished result sits
// in the output register; while the receiver stalls, the engine still takes
// the next operation and works on it, then holds until the register frees.
// Reset removes the list and clears the length and any pending result; the
// element memory is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
// Ordered list engine top level
// Joins the controller and the datapath and checks result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_list_engine_top_defines.svh"

module ordered_list_engine_top (
  input  logic        clk,
  input  logic        rst,
  olist_in_if.sink    in_ch,
  olist_out_if.source out_ch
);
  import olist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olist_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  olist_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // Result consistency and one-at-a-time operation.
  `OLE_ASSERT_SAME(a_empty_len, out_ch.valid && out_ch.list_empty, out_ch.list_length == 8'd0)
  `OLE_ASSERT_SAME(a_len_cap, out_ch.valid, out_ch.list_length <= 8'(CAPACITY))
  `OLE_ASSERT_SAME(a_fail_zero, out_ch.valid && out_ch.status != ST_OK, out_ch.out_value == 32'sd0 && out_ch.out_position == 8'd0)
  `OLE_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
